// ----- rtl/rbd_pkg.sv -----
// Shared constants for the ring buffer deque: field widths, operation codes,
// status codes and the default depth. No dependencies.
package rbd_pkg;

    localparam int DEPTH_DEF = 64;
    localparam int DATA_W    = 32;
    localparam int OP_W      = 3;
    localparam int STAT_W    = 2;

    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
    localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
    localparam logic [OP_W-1:0] OP_DUMP_FWD   = 3'd4;
    localparam logic [OP_W-1:0] OP_DUMP_BWD   = 3'd5;

    localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

endpackage

// ----- rtl/ring_buffer_deque.sv -----
// Ring buffer deque top level: request handshake, head/tail/occupancy control
// and the dump walker. Depends on rbd_pkg and rbd_store.
//
// A double-ended queue of signed 32-bit words kept in a circular store of
// DEPTH entries (any value, not only powers of two). Each request carries
// an operation and a value. Push front/back, pop front/back and the unused
// codes each give one status result; with the output drained every cycle a
// new request is taken each cycle. A dump of n elements gives n results: the
// store has a single read port with registered read data, so accepting the
// dump issues the first read and then, while the output is not stalled, one
// element leaves per cycle, the last one flagged by last_of_run. No request
// is taken while a dump runs. A dump of an empty deque gives one result with
// status empty. The store needs no clearing pass after reset: only occupied
// entries are ever read. A new request is taken only while the output
// register is empty or being emptied in the same cycle, so a result waiting
// on out_ready holds the input off.
module ring_buffer_deque #(
    parameter int DEPTH = rbd_pkg::DEPTH_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [rbd_pkg::OP_W-1:0]              operation,
    input  logic signed [rbd_pkg::DATA_W-1:0]      push_value,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [rbd_pkg::DATA_W-1:0]      data_word,
    output logic [rbd_pkg::STAT_W-1:0]            status,
    output logic                                  last_of_run,
    output logic                                  now_empty,
    output logic                                  now_full
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int OCC_W = $clog2(DEPTH + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
    localparam logic [OCC_W-1:0] OCC_MAX  = OCC_W'(DEPTH);
    localparam logic [OCC_W-1:0] OCC_ONE  = OCC_W'(1);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_DUMP = 2'b10
    } state_t;

    // Wrap helpers; DEPTH need not be a power of two.
    function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] i);
        return (i == LAST_IDX) ? '0 : i + IDX_W'(1);
    endfunction

    function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] i);
        return (i == '0) ? LAST_IDX : i - IDX_W'(1);
    endfunction

    state_t            state_reg, state_next;
    logic [IDX_W-1:0]  head_reg, head_next;
    logic [IDX_W-1:0]  tail_reg, tail_next;
    logic [OCC_W-1:0]  occ_reg, occ_next;
    logic [IDX_W-1:0]  walk_reg, walk_next;
    logic [OCC_W-1:0]  cnt_reg, cnt_next;
    logic              fwd_reg, fwd_next;
    logic              out_valid_reg, out_valid_next;

    logic signed [rbd_pkg::DATA_W-1:0] data_reg, data_next;
    logic [rbd_pkg::STAT_W-1:0]        stat_reg, stat_next;
    logic                              last_reg, last_next;
    logic                              empty_reg, empty_next;
    logic                              full_reg, full_next;

    logic                              out_free;
    logic                              accept;
    logic                              out_load;
    logic                              is_empty;
    logic                              is_full;
    logic                              wr_en;
    logic [IDX_W-1:0]                  wr_addr;
    logic                              rd_en;
    logic [IDX_W-1:0]                  rd_addr;
    logic signed [rbd_pkg::DATA_W-1:0] rd_data;

    rbd_store #(
        .DEPTH(DEPTH)
    ) u_store (
        .clk    (clk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(push_value),
        .rd_en  (rd_en),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    // The output slot frees up when it is empty or being taken this cycle.
    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == S_IDLE) && out_free;
    assign accept   = in_valid && in_ready;
    assign is_empty = (occ_reg == '0);
    assign is_full  = (occ_reg == OCC_MAX);

    always_comb
    begin
        state_next = state_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        occ_next   = occ_reg;
        walk_next  = walk_reg;
        cnt_next   = cnt_reg;
        fwd_next   = fwd_reg;
        wr_en      = 1'b0;
        wr_addr    = '0;
        rd_en      = 1'b0;
        rd_addr    = walk_reg;
        out_load   = 1'b0;
        data_next  = '0;
        stat_next  = rbd_pkg::ST_DONE;
        last_next  = 1'b1;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    out_load = 1'b1;
                    case (operation)
                        rbd_pkg::OP_PUSH_FRONT,
                        rbd_pkg::OP_PUSH_BACK:
                        begin
                            if (is_full)
                            begin
                                stat_next = rbd_pkg::ST_FULL;
                            end
                            else
                            begin
                                wr_en    = 1'b1;
                                occ_next = occ_reg + OCC_ONE;
                                if (is_empty)
                                begin
                                    // First element always lands at entry zero.
                                    head_next = '0;
                                    tail_next = '0;
                                    wr_addr   = '0;
                                end
                                else if (operation == rbd_pkg::OP_PUSH_FRONT)
                                begin
                                    head_next = idx_dec(head_reg);
                                    wr_addr   = idx_dec(head_reg);
                                end
                                else
                                begin
                                    tail_next = idx_inc(tail_reg);
                                    wr_addr   = idx_inc(tail_reg);
                                end
                            end
                        end
                        rbd_pkg::OP_POP_FRONT,
                        rbd_pkg::OP_POP_BACK:
                        begin
                            if (is_empty)
                            begin
                                stat_next = rbd_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                occ_next = occ_reg - OCC_ONE;
                                if (occ_reg == OCC_ONE)
                                begin
                                    head_next = '0;
                                    tail_next = '0;
                                end
                                else if (operation == rbd_pkg::OP_POP_FRONT)
                                begin
                                    head_next = idx_inc(head_reg);
                                end
                                else
                                begin
                                    tail_next = idx_dec(tail_reg);
                                end
                            end
                        end
                        rbd_pkg::OP_DUMP_FWD,
                        rbd_pkg::OP_DUMP_BWD:
                        begin
                            if (is_empty)
                            begin
                                stat_next = rbd_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                // Issue the first read now; results follow.
                                out_load   = 1'b0;
                                state_next = S_DUMP;
                                fwd_next   = (operation == rbd_pkg::OP_DUMP_FWD);
                                rd_en      = 1'b1;
                                cnt_next   = occ_reg;
                                if (operation == rbd_pkg::OP_DUMP_FWD)
                                begin
                                    rd_addr   = head_reg;
                                    walk_next = idx_inc(head_reg);
                                end
                                else
                                begin
                                    rd_addr   = tail_reg;
                                    walk_next = idx_dec(tail_reg);
                                end
                            end
                        end
                        default:
                        begin
                            stat_next = rbd_pkg::ST_DONE;
                        end
                    endcase
                end
            end
            S_DUMP:
            begin
                // Read data is held in the store until the slot frees up.
                if (out_free)
                begin
                    out_load  = 1'b1;
                    data_next = rd_data;
                    last_next = (cnt_reg == OCC_ONE);
                    if (cnt_reg == OCC_ONE)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        rd_en     = 1'b1;
                        rd_addr   = walk_reg;
                        walk_next = fwd_reg ? idx_inc(walk_reg) : idx_dec(walk_reg);
                        cnt_next  = cnt_reg - OCC_ONE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        empty_next = (occ_next == '0);
        full_next  = (occ_next == OCC_MAX);

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            occ_reg       <= '0;
            walk_reg      <= '0;
            cnt_reg       <= '0;
            fwd_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            occ_reg       <= occ_next;
            walk_reg      <= walk_next;
            cnt_reg       <= cnt_next;
            fwd_reg       <= fwd_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload: load on a new result, hold otherwise.
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            data_reg  <= data_next;
            stat_reg  <= stat_next;
            last_reg  <= last_next;
            empty_reg <= empty_next;
            full_reg  <= full_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign data_word   = data_reg;
    assign status      = stat_reg;
    assign last_of_run = last_reg;
    assign now_empty   = empty_reg;
    assign now_full    = full_reg;

endmodule

// ----- rtl/rbd_store.sv -----
// Element store of the ring buffer deque: one write port, one read port with
// registered read data. Depends on rbd_pkg for the word width.
module rbd_store #(
    parameter int DEPTH = rbd_pkg::DEPTH_DEF
) (
    input  logic                                    clk,
    input  logic                                    wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic signed [rbd_pkg::DATA_W-1:0]        wr_data,
    input  logic                                    rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic signed [rbd_pkg::DATA_W-1:0]        rd_data
);

    logic signed [rbd_pkg::DATA_W-1:0] mem [DEPTH];
    logic signed [rbd_pkg::DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Hold read data until the next read is issued.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- bench/ring_buffer_deque_tb.sv -----
// Self-checking bench for ring_buffer_deque: directed, fill/wrap, backpressure
// and random request phases checked against a behavioral deque predictor.
// Depends on rbd_pkg and the ring_buffer_deque RTL.
module ring_buffer_deque_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = rbd_pkg::DEPTH_DEF;

    // Codes the block does not decode; they must still answer with one status result.
    localparam logic [rbd_pkg::OP_W-1:0] OP_SPARE_6 = 3'd6;
    localparam logic [rbd_pkg::OP_W-1:0] OP_SPARE_7 = 3'd7;

    localparam int HOLD_CYCLES  = 400;     // long receiver hold-off
    localparam int DRAIN_CYCLES = 8;       // settle time once nothing is pending
    localparam int DRAIN_LIMIT  = 50000;   // give up waiting for results after this
    localparam int RANDOM_ITEMS = 3;       // per idling phase

    typedef struct {
        logic signed [rbd_pkg::DATA_W-1:0] data;
        logic [rbd_pkg::STAT_W-1:0]        status;
        logic                              last;
        logic                              empty;
        logic                              full;
    } deque_result_t;

    // Clock and reset; every input starts at a known value.
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                              in_valid   = 1'b0;
    logic                              in_ready;
    logic [rbd_pkg::OP_W-1:0]          operation  = rbd_pkg::OP_PUSH_FRONT;
    logic signed [rbd_pkg::DATA_W-1:0] push_value = '0;
    logic                              out_valid;
    logic                              out_ready  = 1'b0;
    logic signed [rbd_pkg::DATA_W-1:0] data_word;
    logic [rbd_pkg::STAT_W-1:0]        status;
    logic                              last_of_run;
    logic                              now_empty;
    logic                              now_full;

    ring_buffer_deque #(
        .DEPTH(DEPTH)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .operation  (operation),
        .push_value (push_value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .data_word  (data_word),
        .status     (status),
        .last_of_run(last_of_run),
        .now_empty  (now_empty),
        .now_full   (now_full)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Predictor state: our own copy of the deque.
    logic signed [rbd_pkg::DATA_W-1:0] shadow_store [DEPTH];
    int unsigned                       shadow_head;
    int unsigned                       shadow_tail;
    int unsigned                       shadow_count;

    // Results predicted for accepted requests, oldest first.
    deque_result_t expected_results [$];

    int error_count    = 0;
    int send_idle_pct  = 0;      // chance in 100 that the sender idles instead of offering
    int recv_stall_pct = 0;      // chance in 100 that the receiver stalls on a given clock
    int hold_ticket    = 0;      // bump to request one long receiver hold-off

    function automatic int unsigned wrap_next(input int unsigned i);
        return (i + 1 >= DEPTH) ? 0 : i + 1;
    endfunction

    function automatic int unsigned wrap_prev(input int unsigned i);
        return (i == 0) ? DEPTH - 1 : i - 1;
    endfunction

    function automatic void queue_result(input logic signed [rbd_pkg::DATA_W-1:0] data,
                                         input logic [rbd_pkg::STAT_W-1:0] st,
                                         input logic last);
        deque_result_t r;
        r.data   = data;
        r.status = st;
        r.last   = last;
        r.empty  = (shadow_count == 0);
        r.full   = (shadow_count >= DEPTH);
        expected_results.push_back(r);
    endfunction

    // Apply one accepted request to the shadow deque and queue what it emits.
    function automatic void predict_request(input logic [rbd_pkg::OP_W-1:0] op,
                                            input logic signed [rbd_pkg::DATA_W-1:0] val);
        logic [rbd_pkg::STAT_W-1:0] st;
        int unsigned                idx;
        bit                         is_full;
        bit                         is_empty;
        st       = rbd_pkg::ST_DONE;
        is_full  = (shadow_count >= DEPTH);
        is_empty = (shadow_count == 0);
        case (op)
            rbd_pkg::OP_PUSH_FRONT, rbd_pkg::OP_PUSH_BACK:
            begin
                if (is_full)
                begin
                    st = rbd_pkg::ST_FULL;
                end
                else
                begin
                    // A push onto an empty deque restarts both indices at entry 0.
                    if (is_empty)
                    begin
                        shadow_head = 0;
                        shadow_tail = 0;
                    end
                    else if (op == rbd_pkg::OP_PUSH_FRONT)
                    begin
                        shadow_head = wrap_prev(shadow_head);
                    end
                    else
                    begin
                        shadow_tail = wrap_next(shadow_tail);
                    end
                    shadow_store[(op == rbd_pkg::OP_PUSH_FRONT) ? shadow_head
                                                                : shadow_tail] = val;
                    shadow_count++;
                end
            end
            rbd_pkg::OP_POP_FRONT, rbd_pkg::OP_POP_BACK:
            begin
                if (is_empty)
                begin
                    st = rbd_pkg::ST_EMPTY;
                end
                else
                begin
                    shadow_count--;
                    if (shadow_count == 0)
                    begin
                        shadow_head = 0;
                        shadow_tail = 0;
                    end
                    else if (op == rbd_pkg::OP_POP_FRONT)
                    begin
                        shadow_head = wrap_next(shadow_head);
                    end
                    else
                    begin
                        shadow_tail = wrap_prev(shadow_tail);
                    end
                end
            end
            rbd_pkg::OP_DUMP_FWD, rbd_pkg::OP_DUMP_BWD:
            begin
                if (is_empty)
                begin
                    st = rbd_pkg::ST_EMPTY;
                end
                else
                begin
                    idx = (op == rbd_pkg::OP_DUMP_FWD) ? shadow_head : shadow_tail;
                    for (int k = 0; k < shadow_count; k++)
                    begin
                        queue_result(shadow_store[idx], rbd_pkg::ST_DONE,
                                     (k + 1 == shadow_count));
                        idx = (op == rbd_pkg::OP_DUMP_FWD) ? wrap_next(idx) : wrap_prev(idx);
                    end
                    return;
                end
            end
            default:
            begin
            end
        endcase
        queue_result('0, st, 1'b1);
    endfunction

    // Receiver: stall at random, or hold off for a long stretch on request.
    int hold_seen = 0;
    int hold_left = 0;

    always @(posedge clk)
    begin
        if (hold_ticket != hold_seen)
        begin
            hold_seen = hold_ticket;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Result checker: every handshake on the output pops the oldest expectation.
    always @(posedge clk)
    begin : check_result
        deque_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
            begin
                $error("unexpected result: data_word %0d status %0d", data_word, status);
                error_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (data_word !== want.data)
                begin
                    $error("data_word: expected %0d, got %0d", want.data, data_word);
                    error_count++;
                end
                if (status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, status);
                    error_count++;
                end
                if (last_of_run !== want.last)
                begin
                    $error("last_of_run: expected %0b, got %0b", want.last, last_of_run);
                    error_count++;
                end
                if (now_empty !== want.empty)
                begin
                    $error("now_empty: expected %0b, got %0b", want.empty, now_empty);
                    error_count++;
                end
                if (now_full !== want.full)
                begin
                    $error("now_full: expected %0b, got %0b", want.full, now_full);
                    error_count++;
                end
            end
        end
    end

    // Offer one request, idling first at the current sender rate, and hold it
    // until accepted. Returns in the time step of the accepting edge.
    task automatic send_request(input logic [rbd_pkg::OP_W-1:0] op,
                                input logic signed [rbd_pkg::DATA_W-1:0] val);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        operation  <= op;
        push_value <= val;
        do
            @(posedge clk);
        while (!in_ready);
        predict_request(op, val);
    endtask

    // Drop valid and wait until every predicted result has come out.
    task automatic wait_drained();
        int spin;
        spin = 0;
        in_valid <= 1'b0;
        while (expected_results.size() != 0 && spin < DRAIN_LIMIT)
        begin
            @(posedge clk);
            spin++;
        end
        if (expected_results.size() != 0)
        begin
            $error("results still missing after %0d cycles: %0d",
                   DRAIN_LIMIT, expected_results.size());
            error_count++;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_stall_pct <= recv_pct;
    endtask

    // Plain random words half the time, with the extremes and simple patterns mixed in.
    function automatic logic signed [rbd_pkg::DATA_W-1:0] pick_word();
        case ($urandom_range(7))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2:       return -1;
            3:       return '0;
            default: return $urandom;
        endcase
    endfunction

    // Bias pushes while the deque is under half full and pops above that,
    // so occupancy wanders instead of sticking at one end.
    function automatic logic [rbd_pkg::OP_W-1:0] pick_operation();
        int unsigned roll;
        int unsigned push_share;
        roll       = $urandom_range(99);
        push_share = (shadow_count < DEPTH / 2) ? 55 : 35;
        if (roll < 3)
            return $urandom_range(1) ? OP_SPARE_6 : OP_SPARE_7;
        if (roll < 11)
            return $urandom_range(1) ? rbd_pkg::OP_DUMP_FWD : rbd_pkg::OP_DUMP_BWD;
        if (roll < 11 + push_share)
            return $urandom_range(1) ? rbd_pkg::OP_PUSH_FRONT : rbd_pkg::OP_PUSH_BACK;
        return $urandom_range(1) ? rbd_pkg::OP_POP_FRONT : rbd_pkg::OP_POP_BACK;
    endfunction

    // Empty-deque refusals, spare codes, extreme words and an empty-again restart.
    task automatic test_directed();
        set_idling(0, 0);
        send_request(rbd_pkg::OP_POP_FRONT, $urandom);         // refuse: empty
        send_request(rbd_pkg::OP_POP_BACK, $urandom);          // refuse: empty
        send_request(rbd_pkg::OP_DUMP_FWD, $urandom);          // empty dump, single result
        send_request(rbd_pkg::OP_DUMP_BWD, $urandom);
        send_request(OP_SPARE_6, $urandom);                    // no state change
        send_request(OP_SPARE_7, $urandom);
        send_request(rbd_pkg::OP_PUSH_FRONT, 32'sh7FFF_FFFF);  // push onto empty
        send_request(rbd_pkg::OP_PUSH_BACK, 32'sh8000_0000);
        send_request(rbd_pkg::OP_PUSH_FRONT, -1);              // head wraps below entry 0
        send_request(rbd_pkg::OP_PUSH_BACK, '0);
        send_request(rbd_pkg::OP_PUSH_FRONT, 32'sh5555_5555);
        send_request(rbd_pkg::OP_PUSH_BACK, 32'shAAAA_AAAA);
        send_request(rbd_pkg::OP_DUMP_FWD, $urandom);
        send_request(rbd_pkg::OP_DUMP_BWD, $urandom);
        send_request(rbd_pkg::OP_POP_FRONT, $urandom);
        send_request(rbd_pkg::OP_POP_BACK, $urandom);
        send_request(OP_SPARE_7, $urandom);                    // flags with elements held
        send_request(rbd_pkg::OP_DUMP_FWD, $urandom);
        repeat (4) send_request(rbd_pkg::OP_POP_FRONT, $urandom); // last pop empties
        send_request(rbd_pkg::OP_POP_BACK, $urandom);
        send_request(rbd_pkg::OP_PUSH_BACK, 32'sh1234_5678);   // restart at entry 0
        send_request(rbd_pkg::OP_DUMP_BWD, $urandom);
        send_request(rbd_pkg::OP_POP_BACK, $urandom);
        wait_drained();
    endtask

    // Fill to DEPTH from both ends, refuse further pushes, dump the full
    // ring both ways, then free one slot and fill it again via the tail.
    task automatic test_fill_and_wrap();
        set_idling(24, 24);
        repeat (DEPTH)
            send_request($urandom_range(1) ? rbd_pkg::OP_PUSH_FRONT : rbd_pkg::OP_PUSH_BACK,
                         pick_word());
        send_request(rbd_pkg::OP_PUSH_FRONT, $urandom);        // refuse: full
        send_request(rbd_pkg::OP_PUSH_BACK, $urandom);
        send_request(OP_SPARE_6, $urandom);                    // full flag on a spare code
        send_request(rbd_pkg::OP_DUMP_FWD, $urandom);
        send_request(rbd_pkg::OP_DUMP_BWD, $urandom);
        send_request(rbd_pkg::OP_POP_BACK, $urandom);          // one free slot
        send_request(rbd_pkg::OP_PUSH_BACK, pick_word());      // full again via the tail
        wait_drained();
    endtask

    // Hold the receiver off while the sender keeps offering, so the output
    // backs up and in_ready drops; then pause the sender until all is drained.
    task automatic test_backpressure();
        set_idling(0, 0);
        hold_ticket <= hold_ticket + 1;
        repeat (4) send_request(rbd_pkg::OP_POP_FRONT, $urandom);
        send_request(rbd_pkg::OP_DUMP_FWD, $urandom);
        wait_drained();
    endtask

    // Random requests under each idling mix, draining between phases.
    task automatic test_random();
        int pct_send [4];
        int pct_recv [4];
        pct_send = '{0, 63, 0, 24};
        pct_recv = '{0, 0, 63, 24};
        for (int ph = 0; ph < 4; ph++)
        begin
            set_idling(pct_send[ph], pct_recv[ph]);
            repeat (RANDOM_ITEMS) send_request(pick_operation(), pick_word());
            wait_drained();
        end
    endtask

    initial
    begin
        shadow_head  = 0;
        shadow_tail  = 0;
        shadow_count = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_fill_and_wrap();
        test_backpressure();
        test_random();

        wait_drained();
        if (expected_results.size() != 0)
        begin
            $error("%0d expected results never arrived", expected_results.size());
            error_count++;
        end
        if (error_count == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial
    begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
